### rtl/sfbc_receive_combiner_top_defines.svh
// assertion macros for the receive combiner rtl
`ifndef SFBC_RECEIVE_COMBINER_TOP_DEFINES_SVH
`define SFBC_RECEIVE_COMBINER_TOP_DEFINES_SVH

// property that must hold in the same cycle as its trigger
`define SFBC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// property that must hold in the cycle after its trigger
`define SFBC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/sfbc_pkg.sv
// shared types and constants of the receive combiner
`default_nettype none
package sfbc_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int PROD_BITS   = 2 * SAMPLE_BITS;
   localparam int ACC_BITS    = 40;
   localparam int GAIN_BITS   = 38;
   localparam int SQRT2_BITS  = 24;
   localparam int MAG_HALF    = ACC_BITS / 2;
   localparam int PLO_BITS    = MAG_HALF + SQRT2_BITS;
   localparam int NUM_BITS    = ACC_BITS + SQRT2_BITS;
   localparam int SCALE_SHIFT = 11;
   localparam int DEN_BITS    = GAIN_BITS + SCALE_SHIFT;
   localparam int DIV_BITS    = NUM_BITS + 2;
   localparam int Q_BITS      = 17;
   localparam int BIT_CNT_BITS = 5;
   localparam int OUT_BITS    = 16;
   localparam int NUM_PARTS   = 4;
   localparam int STEP_BITS   = 2;

   localparam logic [SQRT2_BITS-1:0] SQRT2_Q = 24'd11863283;
   localparam longint GAIN_FLOOR_VAL =
      ((64'sd1 <<< (2 * (SAMPLE_BITS - 1))) + 64'sd5000) / 64'sd10000;
   localparam logic [GAIN_BITS-1:0] GAIN_FLOOR = GAIN_BITS'(GAIN_FLOOR_VAL);
   localparam logic [OUT_BITS-1:0]  SAT_POS = 16'h7fff;
   localparam logic [OUT_BITS-1:0]  SAT_NEG = 16'h8000;
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(NUM_PARTS - 1);

   typedef struct packed {
      logic [31:0] rx_even;
      logic [31:0] rx_odd;
      logic [31:0] chan_a_even;
      logic [31:0] chan_a_odd;
      logic [31:0] chan_b_even;
      logic [31:0] chan_b_odd;
      logic        layer_pair;
      logic        last_antenna;
      logic        last_pair;
   } req_item_type;

   typedef struct packed {
      logic [31:0] first_symbol;
      logic [31:0] second_symbol;
      logic        pair_of_layers;
      logic        end_of_block;
      logic        zero_gain;
   } rsp_item_type;

   typedef struct packed {
      logic                    load_in;
      logic                    acc_en;
      logic [STEP_BITS-1:0]    step;
      logic                    mul_lo;
      logic                    mul_hi;
      logic                    sum;
      logic                    check;
      logic                    div_en;
      logic [BIT_CNT_BITS-1:0] div_bit;
      logic                    store_part;
      logic                    load_out;
      logic                    clear;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last_antenna;
      logic gain_zero;
      logic out_busy;
      logic out_free;
   } dp_status_type;

   // signed sample number idx of a packed complex word
   function automatic logic signed [SAMPLE_BITS-1:0] sample(input logic [31:0] word,
                                                            input logic idx);
      sample = idx ? word[SAMPLE_BITS +: SAMPLE_BITS] : word[0 +: SAMPLE_BITS];
   endfunction

endpackage
`default_nettype wire

### rtl/sfbc_datapath.sv
// datapath: accumulators, gain, multiply and long division for scaling
`default_nettype none
module sfbc_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic                  csr_write_data,
   input  wire sfbc_pkg::req_item_type req_item,
   input  wire logic                  rsp_stall,
   input  wire sfbc_pkg::ctrl_cmd_type cmd,
   output sfbc_pkg::dp_status_type    status,
   output logic                       rsp_valid,
   output sfbc_pkg::rsp_item_type     rsp_item
);

   logic                                   port_mode_ff, port_mode_in;
   sfbc_pkg::req_item_type                 in_ff;
   logic signed [sfbc_pkg::ACC_BITS-1:0]   acc_ff [sfbc_pkg::NUM_PARTS];
   logic [sfbc_pkg::GAIN_BITS-1:0]         gain_ff, gain_in;
   logic [sfbc_pkg::PLO_BITS-1:0]          p_lo_ff;
   logic [sfbc_pkg::PLO_BITS-1:0]          p_hi_ff;
   logic [sfbc_pkg::NUM_BITS-1:0]          rem_ff;
   logic [sfbc_pkg::Q_BITS-1:0]            q_ff;
   logic                                   sat_ff, neg_ff;
   logic [sfbc_pkg::OUT_BITS-1:0]          part_ff [sfbc_pkg::NUM_PARTS];
   logic                                   rsp_valid_ff, rsp_valid_in;
   sfbc_pkg::rsp_item_type                 rsp_ff;

   logic signed [sfbc_pkg::SAMPLE_BITS-1:0] rr, ri, sr, si, ar, ai, er, ei, cr, ci, br, bi;
   logic signed [sfbc_pkg::SAMPLE_BITS-1:0] opa [4];
   logic signed [sfbc_pkg::SAMPLE_BITS-1:0] opb [4];
   logic [3:0]                              neg_sel;
   logic signed [sfbc_pkg::PROD_BITS-1:0]   prod [4];
   logic signed [sfbc_pkg::ACC_BITS-1:0]    acc_sum;
   logic signed [sfbc_pkg::SAMPLE_BITS-1:0] gsel;
   logic signed [sfbc_pkg::PROD_BITS-1:0]   gsq;
   logic [sfbc_pkg::GAIN_BITS-1:0]          gain_sum;
   logic signed [sfbc_pkg::ACC_BITS-1:0]    acc_sel;
   logic [sfbc_pkg::ACC_BITS-1:0]           mag;
   logic [sfbc_pkg::DEN_BITS-1:0]           den;
   logic [sfbc_pkg::DIV_BITS-1:0]           trial;
   logic [sfbc_pkg::DIV_BITS-1:0]           rem_ext;
   logic [sfbc_pkg::OUT_BITS-1:0]           part_val;

   // unpack the held item
   assign rr = sfbc_pkg::sample(in_ff.rx_even, 1'b0);
   assign ri = sfbc_pkg::sample(in_ff.rx_even, 1'b1);
   assign sr = sfbc_pkg::sample(in_ff.rx_odd, 1'b0);
   assign si = sfbc_pkg::sample(in_ff.rx_odd, 1'b1);
   assign ar = sfbc_pkg::sample(in_ff.chan_a_even, 1'b0);
   assign ai = sfbc_pkg::sample(in_ff.chan_a_even, 1'b1);
   assign er = sfbc_pkg::sample(in_ff.chan_a_odd, 1'b0);
   assign ei = sfbc_pkg::sample(in_ff.chan_a_odd, 1'b1);
   assign cr = sfbc_pkg::sample(in_ff.chan_b_even, 1'b0);
   assign ci = sfbc_pkg::sample(in_ff.chan_b_even, 1'b1);
   assign br = sfbc_pkg::sample(in_ff.chan_b_odd, 1'b0);
   assign bi = sfbc_pkg::sample(in_ff.chan_b_odd, 1'b1);

   // operand selection: one accumulator and one gain square per step
   always_comb begin
      case (cmd.step)
         2'd0: begin
            opa = '{ar, ai, br, bi};  opb = '{rr, ri, sr, si};
            neg_sel = 4'b0000;        gsel = ar;
         end
         2'd1: begin
            opa = '{ar, ai, bi, br};  opb = '{ri, rr, sr, si};
            neg_sel = 4'b1010;        gsel = ai;
         end
         2'd2: begin
            opa = '{cr, ci, er, ei};  opb = '{rr, ri, sr, si};
            neg_sel = 4'b0011;        gsel = br;
         end
         default: begin
            opa = '{ci, cr, er, ei};  opb = '{rr, ri, si, sr};
            neg_sel = 4'b1001;        gsel = bi;
         end
      endcase
   end

   // four products summed into the selected accumulator
   always_comb begin
      acc_sum = acc_ff[cmd.step];
      for (int k = 0; k < 4; k++) begin
         prod[k] = opa[k] * opb[k];
         if (neg_sel[k]) begin
            acc_sum = acc_sum - sfbc_pkg::ACC_BITS'(prod[k]);
         end else begin
            acc_sum = acc_sum + sfbc_pkg::ACC_BITS'(prod[k]);
         end
      end
   end

   // gain term with the two-port floor after the last square
   always_comb begin
      gsq = gsel * gsel;
      gain_sum = gain_ff + sfbc_pkg::GAIN_BITS'(unsigned'(gsq));
      gain_in = gain_ff;
      if (cmd.clear) begin
         gain_in = '0;
      end else if (cmd.acc_en) begin
         gain_in = gain_sum;
         if (cmd.step == sfbc_pkg::LAST_STEP && !port_mode_ff && gain_sum == '0) begin
            gain_in = sfbc_pkg::GAIN_FLOOR;
         end
      end
   end

   // magnitude and divisor for the scaling division
   assign acc_sel = acc_ff[cmd.step];
   assign mag     = acc_sel[sfbc_pkg::ACC_BITS-1] ? unsigned'(-acc_sel) : unsigned'(acc_sel);
   assign den     = {gain_ff, sfbc_pkg::SCALE_SHIFT'(0)};
   assign rem_ext = sfbc_pkg::DIV_BITS'(rem_ff);
   assign trial   = sfbc_pkg::DIV_BITS'(den) << cmd.div_bit;

   // rounded, saturated 16-bit result of one part
   always_comb begin
      if (neg_ff) begin
         part_val = (sat_ff || q_ff > sfbc_pkg::Q_BITS'(32768)) ? sfbc_pkg::SAT_NEG
                                                               : -q_ff[sfbc_pkg::OUT_BITS-1:0];
      end else begin
         part_val = (sat_ff || q_ff > sfbc_pkg::Q_BITS'(32767)) ? sfbc_pkg::SAT_POS
                                                               : q_ff[sfbc_pkg::OUT_BITS-1:0];
      end
   end

   // configuration register
   assign port_mode_in = csr_write_enable ? csr_write_data : port_mode_ff;

   // output slot handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state and accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         port_mode_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gain_ff      <= '0;
         for (int k = 0; k < sfbc_pkg::NUM_PARTS; k++) begin
            acc_ff[k] <= '0;
         end
      end else begin
         port_mode_ff <= port_mode_in;
         rsp_valid_ff <= rsp_valid_in;
         gain_ff      <= gain_in;
         if (cmd.clear) begin
            for (int k = 0; k < sfbc_pkg::NUM_PARTS; k++) begin
               acc_ff[k] <= '0;
            end
         end else if (cmd.acc_en) begin
            acc_ff[cmd.step] <= acc_sum;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         in_ff <= req_item;
      end
      if (cmd.mul_lo) begin
         neg_ff  <= acc_sel[sfbc_pkg::ACC_BITS-1];
         p_lo_ff <= sfbc_pkg::PLO_BITS'(mag[sfbc_pkg::MAG_HALF-1:0] * sfbc_pkg::SQRT2_Q);
      end
      if (cmd.mul_hi) begin
         p_hi_ff <= sfbc_pkg::PLO_BITS'(mag[sfbc_pkg::ACC_BITS-1:sfbc_pkg::MAG_HALF]
                                         * sfbc_pkg::SQRT2_Q);
      end
      if (cmd.sum) begin
         rem_ff <= sfbc_pkg::NUM_BITS'({p_hi_ff, sfbc_pkg::MAG_HALF'(0)})
                 + sfbc_pkg::NUM_BITS'(p_lo_ff)
                 + sfbc_pkg::NUM_BITS'({gain_ff, (sfbc_pkg::SCALE_SHIFT - 1)'(0)});
      end
      if (cmd.check) begin
         sat_ff <= rem_ext >= {den, sfbc_pkg::Q_BITS'(0)};
         q_ff   <= '0;
      end
      if (cmd.div_en && rem_ext >= trial) begin
         rem_ff           <= sfbc_pkg::NUM_BITS'(rem_ext - trial);
         q_ff[cmd.div_bit] <= 1'b1;
      end
      if (cmd.store_part) begin
         part_ff[cmd.step] <= part_val;
      end
      if (cmd.load_out) begin
         rsp_ff.first_symbol   <= status.gain_zero ? '0 : {part_ff[1], part_ff[0]};
         rsp_ff.second_symbol  <= status.gain_zero ? '0 : {part_ff[3], part_ff[2]};
         rsp_ff.pair_of_layers <= in_ff.layer_pair;
         rsp_ff.end_of_block   <= in_ff.last_pair;
         rsp_ff.zero_gain      <= status.gain_zero;
      end
   end

   // status to the controller
   assign status.last_antenna = in_ff.last_antenna;
   assign status.gain_zero    = (gain_ff == '0);
   assign status.out_busy     = rsp_valid_ff;
   assign status.out_free     = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
`default_nettype wire

### rtl/sfbc_ctrl.sv
// controller: sequences accumulate steps, per-part scaling and output load
`default_nettype none
`include "sfbc_receive_combiner_top_defines.svh"
module sfbc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire sfbc_pkg::dp_status_type status,
   output sfbc_pkg::ctrl_cmd_type      cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_ACC   = 4'd1;
   localparam logic [3:0] ST_MULLO = 4'd2;
   localparam logic [3:0] ST_MULHI = 4'd3;
   localparam logic [3:0] ST_SUM   = 4'd4;
   localparam logic [3:0] ST_CHECK = 4'd5;
   localparam logic [3:0] ST_DIV   = 4'd6;
   localparam logic [3:0] ST_STORE = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   logic [3:0]                        state_ff, state_in;
   logic [sfbc_pkg::STEP_BITS-1:0]    step_ff, step_in;
   logic [sfbc_pkg::BIT_CNT_BITS-1:0] bit_ff, bit_in;

   assign req_stall = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      bit_in   = bit_ff;
      cmd      = '0;
      cmd.step    = step_ff;
      cmd.div_bit = bit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               step_in     = '0;
               state_in    = ST_ACC;
            end
         end
         ST_ACC: begin
            cmd.acc_en = 1'b1;
            step_in    = step_ff + 1'b1;
            if (step_ff == sfbc_pkg::LAST_STEP) begin
               state_in = status.last_antenna ? ST_MULLO : ST_IDLE;
            end
         end
         ST_MULLO: begin
            if (status.gain_zero) begin
               state_in = ST_OUT;
            end else begin
               cmd.mul_lo = 1'b1;
               state_in   = ST_MULHI;
            end
         end
         ST_MULHI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            bit_in    = sfbc_pkg::BIT_CNT_BITS'(sfbc_pkg::Q_BITS - 1);
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_en = 1'b1;
            bit_in     = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store_part = 1'b1;
            step_in        = step_ff + 1'b1;
            state_in       = (step_ff == sfbc_pkg::LAST_STEP) ? ST_OUT : ST_MULLO;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.clear    = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         bit_ff   <= bit_in;
      end
   end

   // checks
   `SFBC_ASSERT_NEXT(a_accept_starts, req_valid && !req_stall, state_ff == ST_ACC && step_ff == '0, "item accepted but accumulation did not start")
   `SFBC_ASSERT_NEXT(a_out_after_load, cmd.load_out, status.out_busy, "result load did not fill output slot")
   `SFBC_ASSERT_NEXT(a_div_ends, state_ff == ST_DIV && bit_ff == '0, state_ff == ST_STORE, "division did not end in store")

endmodule
`default_nettype wire

### rtl/sfbc_receive_combiner_top.sv
// top level of the alamouti sfbc receive combiner
// Usage: one req item per receive antenna carries the received even/odd
// elements and four channel estimates (packed Q1.15 complex). Items of one
// pair accumulate the two combiner sums and the channel gain; the item with
// last_antenna set produces one rsp item with both symbols in Q4.12.
// Handshake: req and rsp use valid/stall; an item moves at a clock edge with
// valid high and stall low. csr_write_enable writes port_mode (0 two ports
// with zero-gain floor, 1 four ports, zero gain gives zero symbols and flag).
// Sequence: an item is taken in an idle cycle and accumulated in four steps,
// one accumulator per step through four 16x16 multipliers. req_stall is
// high whenever the controller is not idle, so no item is taken before the
// last one is through. The last antenna adds 4 scaling passes (two 20x24
// partial products, sum, range check, 17-step restoring division) and one
// output load that sets rsp_valid; zero gain skips the scaling passes.
// Reset clears mode, accumulators and the output slot.
// While rsp_stall holds a result, new antennas are still accumulated; only
// the next result load waits for the slot to empty.
`default_nettype none
module sfbc_receive_combiner_top (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire sfbc_pkg::req_item_type req_item,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output sfbc_pkg::rsp_item_type      rsp_item,
   input  wire logic                   csr_write_enable,
   input  wire logic                   csr_write_data
);

   sfbc_pkg::ctrl_cmd_type  cmd;
   sfbc_pkg::dp_status_type status;

   // sequencer
   sfbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic
   sfbc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_item         (req_item),
      .rsp_stall        (rsp_stall),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_item         (rsp_item)
   );

endmodule
`default_nettype wire
